### sv/ffrp_pkg.sv
// Shared types for the first-fit rectangle placer.
package ffrp_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_ACC,
        S_COL,
        S_MRD,
        S_MWR,
        S_FOUND,
        S_MISS
    } state_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic acc;
        logic col_step;
        logic hit;
        logic top_next;
        logic mwr;
        logic out_load;
        logic out_found;
    } cmd_t;

    typedef struct packed {
        logic reject;
        logic last_row;
        logic bit_free;
        logic run_hit;
        logic last_col;
        logic top_last;
        logic out_free;
    } status_t;

endpackage

### sv/ffrp_ctrl.sv
// Sequencer for the placement scan and the marking pass.
module ffrp_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ffrp_pkg::status_t st,
    output ffrp_pkg::cmd_t    cmd
);

    ffrp_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffrp_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ffrp_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = st.reject ? ffrp_pkg::S_MISS : ffrp_pkg::S_RD;
                end
            end
            ffrp_pkg::S_RD:  state_next = ffrp_pkg::S_ACC;
            ffrp_pkg::S_ACC: state_next = st.last_row ? ffrp_pkg::S_COL : ffrp_pkg::S_RD;
            ffrp_pkg::S_COL: begin
                priority if (st.bit_free && st.run_hit) begin
                    state_next = ffrp_pkg::S_MRD;
                end else if (st.last_col) begin
                    state_next = st.top_last ? ffrp_pkg::S_MISS : ffrp_pkg::S_RD;
                end
            end
            ffrp_pkg::S_MRD: state_next = ffrp_pkg::S_MWR;
            ffrp_pkg::S_MWR: state_next = st.last_row ? ffrp_pkg::S_FOUND : ffrp_pkg::S_MRD;
            ffrp_pkg::S_FOUND, ffrp_pkg::S_MISS: begin
                if (st.out_free) begin
                    state_next = ffrp_pkg::S_IDLE;
                end
            end
            default: state_next = ffrp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ffrp_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ffrp_pkg::S_RD:  cmd.rd  = 1'b1;
            ffrp_pkg::S_ACC: cmd.acc = 1'b1;
            ffrp_pkg::S_COL: begin
                cmd.col_step = 1'b1;
                cmd.hit      = st.bit_free && st.run_hit;
                cmd.top_next = !(st.bit_free && st.run_hit) && st.last_col && !st.top_last;
            end
            ffrp_pkg::S_MRD: cmd.rd  = 1'b1;
            ffrp_pkg::S_MWR: cmd.mwr = 1'b1;
            ffrp_pkg::S_FOUND: begin
                cmd.out_load  = st.out_free;
                cmd.out_found = 1'b1;
            end
            ffrp_pkg::S_MISS: cmd.out_load = st.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

### sv/ffrp_dp.sv
// Occupancy memory, scan counters, window accumulator and result register.
module ffrp_dp #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [6:0]        grid_rows,
    input  logic [6:0]        grid_cols,
    input  logic [6:0]        s_rect_rows,
    input  logic [6:0]        s_rect_cols,
    input  ffrp_pkg::cmd_t    cmd,
    output ffrp_pkg::status_t st,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_found,
    output logic [5:0]        m_top_row,
    output logic [5:0]        m_left_col
);

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RN = (RW + 2 > 8) ? RW + 2 : 8;
    localparam int CN = (CW + 2 > 8) ? CW + 2 : 8;

    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] row_valid_reg;
    logic [MAX_COLS-1:0] rdata_reg;
    logic                rvalid_reg;
    logic [MAX_COLS-1:0] rd_eff;
    logic [MAX_COLS-1:0] acc_reg;
    logic [MAX_COLS-1:0] mask;

    logic [RN-1:0] top_reg, row_reg, gr_reg;
    logic [CN-1:0] col_reg, run_reg, left_reg, gc_reg;
    logic [6:0]    rh_reg, rw_reg;
    logic [RN-1:0] gr_sat, rh_ext;
    logic [CN-1:0] gc_sat, rw_ext;

    logic          m_valid_reg, found_reg;
    logic [5:0]    top_out_reg, left_out_reg;

    assign gr_sat = (RN'(grid_rows) > RN'(MAX_ROWS)) ? RN'(MAX_ROWS) : RN'(grid_rows);
    assign gc_sat = (CN'(grid_cols) > CN'(MAX_COLS)) ? CN'(MAX_COLS) : CN'(grid_cols);
    assign rh_ext = RN'(rh_reg);
    assign rw_ext = CN'(rw_reg);
    assign rd_eff = rvalid_reg ? rdata_reg : '0;

    always_comb begin
        for (int c = 0; c < MAX_COLS; c++) begin
            mask[c] = (CN'(c) >= left_reg) && (CN'(c) < left_reg + rw_ext);
        end
    end

    assign st.reject   = (s_rect_rows == 7'd0) || (s_rect_cols == 7'd0)
                      || (RN'(s_rect_rows) > gr_sat) || (CN'(s_rect_cols) > gc_sat);
    assign st.last_row = (row_reg == top_reg + rh_ext - RN'(1));
    assign st.bit_free = !acc_reg[col_reg[CW-1:0]];
    assign st.run_hit  = (run_reg + CN'(1) == rw_ext);
    assign st.last_col = (col_reg == gc_reg - CN'(1));
    assign st.top_last = (top_reg + RN'(1) + rh_ext > gr_reg);
    assign st.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rdata_reg  <= mem[row_reg[RW-1:0]];
            rvalid_reg <= row_valid_reg[row_reg[RW-1:0]];
        end
        if (cmd.mwr) begin
            mem[row_reg[RW-1:0]] <= rd_eff | mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (cmd.mwr) begin
            row_valid_reg[row_reg[RW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rh_reg  <= s_rect_rows;
            rw_reg  <= s_rect_cols;
            gr_reg  <= gr_sat;
            gc_reg  <= gc_sat;
            top_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
            run_reg <= '0;
            acc_reg <= '0;
        end else if (cmd.top_next) begin
            top_reg <= top_reg + RN'(1);
            row_reg <= top_reg + RN'(1);
            col_reg <= '0;
            run_reg <= '0;
            acc_reg <= '0;
        end else if (cmd.hit) begin
            left_reg <= col_reg + CN'(1) - rw_ext;
            row_reg  <= top_reg;
        end else if (cmd.acc) begin
            acc_reg <= acc_reg | rd_eff;
            row_reg <= row_reg + RN'(1);
        end else if (cmd.mwr) begin
            row_reg <= row_reg + RN'(1);
        end else if (cmd.col_step) begin
            col_reg <= col_reg + CN'(1);
            run_reg <= st.bit_free ? run_reg + CN'(1) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            found_reg    <= cmd.out_found;
            top_out_reg  <= cmd.out_found ? 6'(top_reg) : 6'd0;
            left_out_reg <= cmd.out_found ? 6'(left_reg) : 6'd0;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_found    = found_reg;
    assign m_top_row  = top_out_reg;
    assign m_left_col = left_out_reg;

endmodule

### sv/first_fit_rect_placer_unit.sv
// First-fit rectangle placer: top level with the grid size registers.
// Each request is scanned one candidate top row at a time: the rectangle's rows
// are read from the single-port occupancy memory and ORed together, then the
// combined row is walked one column a cycle looking for a free run of the
// rectangle's width. A placement is then marked by rewriting the rectangle's
// rows, and a rejected request goes straight to a miss result.
// One request is in work at a time; the result register holds a finished
// result while the next request is scanned. Occupancy rows carry valid bits
// cleared by reset, so no clearing pass is needed.
module first_fit_rect_placer_unit #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [6:0]  s_rect_rows,
    input  logic [6:0]  s_rect_cols,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [5:0]  m_top_row,
    output logic [5:0]  m_left_col
);

    localparam logic ADDR_GRID_ROWS = 1'b0;
    localparam logic ADDR_GRID_COLS = 1'b1;

    logic [6:0]        grid_rows_reg, grid_cols_reg;
    ffrp_pkg::cmd_t    cmd;
    ffrp_pkg::status_t st;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= 7'd64;
            grid_cols_reg <= 7'd64;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                ADDR_GRID_ROWS: grid_rows_reg <= pwdata[6:0];
                ADDR_GRID_COLS: grid_cols_reg <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[2] == ADDR_GRID_COLS) ? {25'd0, grid_cols_reg}
                                                 : {25'd0, grid_rows_reg};

    ffrp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    ffrp_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .grid_rows   (grid_rows_reg),
        .grid_cols   (grid_cols_reg),
        .s_rect_rows (s_rect_rows),
        .s_rect_cols (s_rect_cols),
        .cmd         (cmd),
        .st          (st),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_found     (m_found),
        .m_top_row   (m_top_row),
        .m_left_col  (m_left_col)
    );

endmodule

### sv/ffrp_checker.sv
// Port-level checks for the placer, bound to the top level.
module ffrp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_found,
    input logic [5:0] m_top_row,
    input logic [5:0] m_left_col
);

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in work");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_top_row == 6'd0 && m_left_col == 6'd0))
        else $error("miss result carries a nonzero position");

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before taken");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_found) && $stable(m_top_row)
                                   && $stable(m_left_col)))
        else $error("result changed while stalled");

endmodule

bind first_fit_rect_placer_unit ffrp_checker u_ffrp_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_found    (m_found),
    .m_top_row  (m_top_row),
    .m_left_col (m_left_col)
);
